[hdl/ps2mcd_pkg.sv]
// shared types and constants for the ps/2 mouse packet and click detector
package ps2mcd_pkg;

    // packet decoder phase
    typedef enum logic [1:0] {
        PKT_FIRST = 2'd0,
        PKT_X     = 2'd1,
        PKT_Y     = 2'd2,
        PKT_ACK   = 2'd3
    } pkt_phase_t;

    // multi-click machine phase
    typedef enum logic [1:0] {
        CLK_CLEAN   = 2'd0,
        CLK_PRESS   = 2'd1,
        CLK_RELEASE = 2'd2,
        CLK_DIRTY   = 2'd3
    } click_phase_t;

    // configuration register indexes
    localparam logic [2:0] CFG_SCREEN_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_SCREEN_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_MOVE_TOL_X    = 3'd2;
    localparam logic [2:0] CFG_MOVE_TOL_Y    = 3'd3;
    localparam logic [2:0] CFG_PRESS_TO      = 3'd4;
    localparam logic [2:0] CFG_RELEASE_TO    = 3'd5;
    localparam logic [2:0] CFG_DIRTY_TO      = 3'd6;

    // item kinds on the input side
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // protocol constants
    localparam logic [7:0] ACK_BYTE = 8'hFA;
    localparam logic [8:0] BIG_MOVE = 9'h100;

    // bit positions in the first packet byte
    localparam int X_SIGN_BIT = 4;
    localparam int Y_SIGN_BIT = 5;
    localparam int X_OVF_BIT  = 6;
    localparam int Y_OVF_BIT  = 7;

    // result item layout
    localparam int OUT_DATA_W = 56;

endpackage

[hdl/ps2_mouse_packet_click_detector_unit.sv]
// Top level of the ps/2 mouse packet decoder with multi-click detection.
//
// Input items arrive on s_axis: tuser carries the kind (0 = mouse byte,
// 1 = millisecond tick) and tdata[7:0] the received byte. Every accepted
// item gives exactly one result item on m_axis with the clamped pointer
// position, packet flags, held buttons and any finished click report. The
// user must write configuration (screen size, drift tolerances, timeouts)
// via cfg_we / cfg_addr / cfg_data only while idle; this is not enforced.
//
// The whole decode and click update sit between the input handshake and
// the result register. One item is taken in every cycle while m_axis does
// not stall; the single result register holds the result while m_axis
// stalls, and s_axis_tready stays high as long as that register is empty
// or being drained in the same cycle.
//
// After reset the decoder waits for the 0xFA acknowledge before it frames
// packets, the pointer sits at zero, the click machine is clean, the timer
// is expired and the configuration registers take their default values.
module ps2_mouse_packet_click_detector_unit
    import ps2mcd_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int TIMER_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // input items
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [7:0]            s_axis_tdata,   // data[7:0]
    input  logic                  s_axis_tuser,   // op[0]
    // result items
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // pointer_x[15:0], pointer_y[31:16], packet_done[32], moved[33],
    // buttons_held[36:34], click_valid[37], click_count[45:38],
    // click_button[48:46], zero[55:49]
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // configuration write port
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_addr,
    input  logic [15:0]           cfg_data
);

    localparam int SUM_W  = COORD_BITS + 2;
    localparam int LOAD_W = (TIMER_BITS > 16) ? TIMER_BITS : 16;

    // configuration registers
    logic [15:0] screen_width_reg, screen_height_reg;
    logic [7:0]  move_tol_x_reg, move_tol_y_reg;
    logic [15:0] press_to_reg, release_to_reg, dirty_to_reg;

    // decoder and click state
    pkt_phase_t             pkt_phase_reg, pkt_phase_next;
    logic [7:0]             first_byte_reg, first_byte_next;
    logic [COORD_BITS-1:0]  pos_x_reg, pos_x_next, pos_y_reg, pos_y_next;
    logic                   moved_flag_reg, moved_flag_next;
    logic [2:0]             held_reg, held_next;
    click_phase_t           click_phase_reg, click_phase_next;
    logic [COORD_BITS-1:0]  anchor_x_reg, anchor_x_next, anchor_y_reg, anchor_y_next;
    logic [2:0]             click_which_reg, click_which_next;
    logic [7:0]             click_tally_reg, click_tally_next;
    logic [TIMER_BITS-1:0]  timer_reg, timer_next;

    // result register
    logic                   out_valid_reg;
    logic [OUT_DATA_W-1:0]  out_data_reg, out_data_next;

    logic                   accept;
    logic [COORD_BITS-1:0]  lim_x, lim_y;

    // saturate a 16-bit timeout into the timer width
    function automatic logic [TIMER_BITS-1:0] load_sat(input logic [15:0] v);
        logic [LOAD_W-1:0] ext;
        logic [LOAD_W-1:0] tmax;
        ext  = LOAD_W'(v);
        tmax = LOAD_W'({TIMER_BITS{1'b1}});
        return TIMER_BITS'((ext > tmax) ? tmax : ext);
    endfunction

    // largest reachable coordinate for a given screen size
    function automatic logic [COORD_BITS-1:0] upper_clamp(input logic [15:0] size);
        logic [15:0] lim;
        logic [15:0] cmax;
        lim  = (size == 16'd0) ? 16'd0 : size - 16'd1;
        cmax = 16'({COORD_BITS{1'b1}});
        return COORD_BITS'((lim > cmax) ? cmax : lim);
    endfunction

    // move towards the upper clamp
    function automatic logic [COORD_BITS-1:0] grow(input logic [COORD_BITS-1:0] pos,
                                                   input logic [8:0] mag,
                                                   input logic [COORD_BITS-1:0] lim);
        logic [SUM_W-1:0] s;
        s = SUM_W'(pos) + SUM_W'(mag);
        return (s >= SUM_W'(lim)) ? lim : COORD_BITS'(s);
    endfunction

    // move towards zero, saturating
    function automatic logic [COORD_BITS-1:0] shrink(input logic [COORD_BITS-1:0] pos,
                                                     input logic [8:0] mag);
        logic [SUM_W-1:0] p;
        logic [SUM_W-1:0] m;
        p = SUM_W'(pos);
        m = SUM_W'(mag);
        return (p > m) ? COORD_BITS'(p - m) : '0;
    endfunction

    // absolute distance beyond tolerance
    function automatic logic drifted(input logic [COORD_BITS-1:0] a,
                                     input logic [COORD_BITS-1:0] b,
                                     input logic [7:0] tol);
        logic [COORD_BITS-1:0] d;
        d = (a > b) ? a - b : b - a;
        return 16'(d) > 16'(tol);
    endfunction

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    assign lim_x = upper_clamp(screen_width_reg);
    assign lim_y = upper_clamp(screen_height_reg);

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= 16'd1024;
            screen_height_reg <= 16'd768;
            move_tol_x_reg    <= 8'd16;
            move_tol_y_reg    <= 8'd16;
            press_to_reg      <= 16'd360;
            release_to_reg    <= 16'd360;
            dirty_to_reg      <= 16'd360;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data;
                CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_data;
                CFG_MOVE_TOL_X:    move_tol_x_reg    <= cfg_data[7:0];
                CFG_MOVE_TOL_Y:    move_tol_y_reg    <= cfg_data[7:0];
                CFG_PRESS_TO:      press_to_reg      <= cfg_data;
                CFG_RELEASE_TO:    release_to_reg    <= cfg_data;
                CFG_DIRTY_TO:      dirty_to_reg      <= cfg_data;
                default:           ;
            endcase
        end
    end

    // decode, pointer update and click machine for one item
    always_comb
    begin
        logic [7:0] v;
        logic [8:0] mag;
        logic [2:0] btn;
        logic       done;
        logic       mv;
        logic       cvalid;
        logic [7:0] ccount;
        logic [2:0] cbutton;
        logic       single;

        v       = s_axis_tdata;
        mag     = '0;
        btn     = '0;
        done    = 1'b0;
        mv      = 1'b0;
        cvalid  = 1'b0;
        ccount  = '0;
        cbutton = '0;
        single  = 1'b0;

        pkt_phase_next   = pkt_phase_reg;
        first_byte_next  = first_byte_reg;
        pos_x_next       = pos_x_reg;
        pos_y_next       = pos_y_reg;
        moved_flag_next  = moved_flag_reg;
        held_next        = held_reg;
        click_phase_next = click_phase_reg;
        anchor_x_next    = anchor_x_reg;
        anchor_y_next    = anchor_y_reg;
        click_which_next = click_which_reg;
        click_tally_next = click_tally_reg;
        timer_next       = timer_reg;

        if (s_axis_tuser == OP_TICK)
        begin
            // tick: count down, then report an expired press or release
            if (timer_next != '0)
                timer_next = timer_next - TIMER_BITS'(1);
            if (timer_next == '0 &&
                (click_phase_next == CLK_PRESS || click_phase_next == CLK_RELEASE))
            begin
                click_phase_next = CLK_DIRTY;
                timer_next       = load_sat(dirty_to_reg);
                cvalid           = 1'b1;
                ccount           = click_tally_reg;
                cbutton          = click_which_reg;
            end
        end
        else
        begin
            case (pkt_phase_reg)
                PKT_FIRST:
                begin
                    first_byte_next = v;
                    pkt_phase_next  = PKT_X;
                end
                PKT_X:
                begin
                    // x delta, sign set means leftwards
                    if (v != 8'd0)
                    begin
                        if (first_byte_reg[X_SIGN_BIT])
                        begin
                            mag = first_byte_reg[X_OVF_BIT] ? BIG_MOVE : BIG_MOVE - {1'b0, v};
                            pos_x_next = shrink(pos_x_reg, mag);
                        end
                        else
                        begin
                            mag = first_byte_reg[X_OVF_BIT] ? BIG_MOVE : {1'b0, v};
                            pos_x_next = grow(pos_x_reg, mag, lim_x);
                        end
                        moved_flag_next = 1'b1;
                    end
                    else
                        moved_flag_next = 1'b0;
                    pkt_phase_next = PKT_Y;
                end
                PKT_Y:
                begin
                    // y delta, screen-down so a negative mouse delta grows y
                    if (v != 8'd0)
                    begin
                        if (first_byte_reg[Y_SIGN_BIT])
                        begin
                            mag = first_byte_reg[Y_OVF_BIT] ? BIG_MOVE : BIG_MOVE - {1'b0, v};
                            pos_y_next = grow(pos_y_reg, mag, lim_y);
                        end
                        else
                        begin
                            mag = first_byte_reg[Y_OVF_BIT] ? BIG_MOVE : {1'b0, v};
                            pos_y_next = shrink(pos_y_reg, mag);
                        end
                        moved_flag_next = 1'b1;
                    end
                    done = 1'b1;

                    // drift away from the press point spoils the click
                    if (moved_flag_next)
                    begin
                        mv              = 1'b1;
                        moved_flag_next = 1'b0;
                        if ((click_phase_next == CLK_PRESS ||
                             click_phase_next == CLK_RELEASE) &&
                            (drifted(anchor_x_reg, pos_x_next, move_tol_x_reg) ||
                             drifted(anchor_y_reg, pos_y_next, move_tol_y_reg)))
                        begin
                            click_phase_next = CLK_DIRTY;
                            timer_next       = load_sat(dirty_to_reg);
                        end
                    end

                    // button change drives the click machine
                    btn = first_byte_reg[2:0];
                    if ((held_reg ^ btn) != 3'b000)
                    begin
                        if (click_phase_next == CLK_DIRTY)
                        begin
                            if (held_reg != 3'b000)
                                timer_next = load_sat(dirty_to_reg);
                            else if (timer_next == '0)
                                click_phase_next = CLK_CLEAN;
                        end
                        if (click_phase_next != CLK_DIRTY)
                        begin
                            single = (btn == 3'b000) || (btn == 3'b001) ||
                                     (btn == 3'b010) || (btn == 3'b100);
                            if (single)
                            begin
                                if (click_phase_next == CLK_CLEAN)
                                begin
                                    click_phase_next = CLK_PRESS;
                                    anchor_x_next    = pos_x_next;
                                    anchor_y_next    = pos_y_next;
                                    click_which_next = btn;
                                    click_tally_next = 8'd0;
                                    timer_next       = load_sat(press_to_reg);
                                end
                                else if (click_phase_next == CLK_PRESS)
                                begin
                                    if (timer_next != '0)
                                    begin
                                        click_phase_next = CLK_RELEASE;
                                        click_tally_next = click_tally_reg + 8'd1;
                                        timer_next       = load_sat(release_to_reg);
                                    end
                                    else
                                    begin
                                        click_phase_next = CLK_DIRTY;
                                        timer_next       = load_sat(dirty_to_reg);
                                    end
                                end
                                else if (timer_next != '0)
                                begin
                                    if (btn == click_which_reg)
                                    begin
                                        click_phase_next = CLK_PRESS;
                                        click_tally_next = click_tally_reg + 8'd1;
                                        timer_next       = load_sat(press_to_reg);
                                    end
                                    else
                                    begin
                                        click_phase_next = CLK_DIRTY;
                                        timer_next       = load_sat(dirty_to_reg);
                                    end
                                end
                            end
                            else
                            begin
                                click_phase_next = CLK_DIRTY;
                                timer_next       = load_sat(dirty_to_reg);
                            end
                        end
                        held_next = btn;
                    end
                    pkt_phase_next = PKT_FIRST;
                end
                PKT_ACK:
                begin
                    if (v == ACK_BYTE)
                        pkt_phase_next = PKT_FIRST;
                end
                default:
                    pkt_phase_next = PKT_ACK;
            endcase
        end

        out_data_next = {7'd0, cbutton, ccount, cvalid, held_next, mv, done,
                         16'(pos_y_next), 16'(pos_x_next)};
    end

    // state registers, updated on each accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pkt_phase_reg   <= PKT_ACK;
            first_byte_reg  <= '0;
            pos_x_reg       <= '0;
            pos_y_reg       <= '0;
            moved_flag_reg  <= 1'b0;
            held_reg        <= '0;
            click_phase_reg <= CLK_CLEAN;
            anchor_x_reg    <= '0;
            anchor_y_reg    <= '0;
            click_which_reg <= '0;
            click_tally_reg <= '0;
            timer_reg       <= '0;
        end
        else if (accept)
        begin
            pkt_phase_reg   <= pkt_phase_next;
            first_byte_reg  <= first_byte_next;
            pos_x_reg       <= pos_x_next;
            pos_y_reg       <= pos_y_next;
            moved_flag_reg  <= moved_flag_next;
            held_reg        <= held_next;
            click_phase_reg <= click_phase_next;
            anchor_x_reg    <= anchor_x_next;
            anchor_y_reg    <= anchor_y_next;
            click_which_reg <= click_which_next;
            click_tally_reg <= click_tally_next;
            timer_reg       <= timer_next;
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (accept)
            out_data_reg <= out_data_next;
    end

endmodule

[hdl/ps2mcd_checker.sv]
// port-level checker for the ps/2 mouse packet and click detector, with its bind
module ps2mcd_checker
    import ps2mcd_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // an empty result register never blocks the input side
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty result register");

    // moved only reported with a finished packet
    a_moved: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[33] |-> m_axis_tdata[32])
        else $error("moved without packet_done");

    // click report comes from a tick, never with a packet, and is zero otherwise
    a_click: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[37] && m_axis_tdata[32]) &&
                          (m_axis_tdata[37] || m_axis_tdata[48:38] == 11'd0))
        else $error("bad click report fields");

endmodule

bind ps2_mouse_packet_click_detector_unit ps2mcd_checker u_ps2mcd_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
